// ===== src/ffp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffp_pkg;

    localparam int SIZE_W  = 7;
    localparam int IDX_W   = 4;
    localparam int JOB_W   = 8;
    localparam int STAT_W  = 2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Search token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic              active;
        logic              cmd;
        logic [SIZE_W-1:0] req;
        logic              found;
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] frag;
    } token_t;

endpackage

`default_nettype wire

// ===== src/ffp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ffp_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [ffp_pkg::SIZE_W-1:0]  req_size;
    logic [ffp_pkg::JOB_W-1:0]   job_id;

    modport source (output valid, cmd, req_size, job_id, input ready);
    modport sink   (input valid, cmd, req_size, job_id, output ready);
endinterface

`default_nettype wire

// ===== src/ffp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ffp_out_if;
    logic                        valid;
    logic                        ready;
    logic [ffp_pkg::STAT_W-1:0]  status;
    logic [ffp_pkg::IDX_W-1:0]   block_index;
    logic [ffp_pkg::SIZE_W-1:0]  start_addr;
    logic [ffp_pkg::SIZE_W-1:0]  end_addr;
    logic [ffp_pkg::SIZE_W-1:0]  block_size;
    logic [ffp_pkg::SIZE_W-1:0]  frag;

    modport source (output valid, status, block_index, start_addr, end_addr, block_size, frag,
                    input ready);
    modport sink   (input valid, status, block_index, start_addr, end_addr, block_size, frag,
                    output ready);
endinterface

`default_nettype wire

// ===== src/fixed_partition_first_fit.sv =====
// An accepted request launches a search token from launch_reg; its result is held
// in res_reg and then registered onto rsp. The token walks the row of partition
// cells one cell per cycle, and only one token is in flight.
// A finished response waits in the output register while the next request is taken.
// Reset (async, active low) leaves entry 0 as the busy OS block and all others empty.
`timescale 1ns / 1ps
`default_nettype none

module fixed_partition_first_fit #(
    parameter int MEM_SIZE   = 80,
    parameter int OS_SIZE    = 20,
    parameter int MAX_BLOCKS = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    ffp_in_if.sink     req,
    ffp_out_if.source  rsp
);
    import ffp_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SIZE_W-1:0] used_top_reg, used_top_next;
    token_t            launch_reg, launch_next;
    token_t            res_reg, res_next;
    token_t            chain [0:MAX_BLOCKS];

    logic              rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [SIZE_W-1:0] start_reg, start_next;
    logic [SIZE_W-1:0] end_reg, end_next;
    logic [SIZE_W-1:0] bsize_reg, bsize_next;
    logic [SIZE_W-1:0] frag_reg, frag_next;

    logic              accept;
    logic              full;
    logic [SIZE_W-1:0] room;
    logic [SIZE_W-1:0] add_size;
    token_t            tok_end;

    assign chain[0] = launch_reg;
    assign tok_end  = chain[MAX_BLOCKS];

    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        ffp_cell #(
            .CELL_IDX (g),
            .OS_SIZE  (OS_SIZE)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        full     = (count_reg >= CNT_W'(MAX_BLOCKS)) || (used_top_reg >= SIZE_W'(MEM_SIZE));
        room     = SIZE_W'(MEM_SIZE) - used_top_reg;
        add_size = (req.req_size > room) ? room : req.req_size;

        state_next     = state_reg;
        count_next     = count_reg;
        used_top_next  = used_top_reg;
        launch_next    = '0;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        index_next     = index_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        bsize_next     = bsize_reg;
        frag_next      = frag_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    launch_next.active = 1'b1;
                    launch_next.cmd    = req.cmd;
                    launch_next.req    = req.req_size;
                    launch_next.status = ST_OK;
                    if (req.cmd == CMD_ADD)
                    begin
                        launch_next.start = used_top_reg;
                        launch_next.size  = add_size;
                        if (full)
                        begin
                            launch_next.status = ST_FULL;
                            launch_next.found  = 1'b1;
                        end
                        else if (req.req_size == '0)
                        begin
                            launch_next.status = ST_ZERO;
                            launch_next.found  = 1'b1;
                        end
                        else
                        begin
                            count_next    = count_reg + CNT_W'(1);
                            used_top_next = used_top_reg + add_size;
                        end
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok_end.active)
                begin
                    res_next = tok_end;
                    if ((tok_end.cmd == CMD_ALLOC) && !tok_end.found)
                    begin
                        res_next.status = ST_NOFIT;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_reg.status;
                    if (res_reg.status == ST_OK)
                    begin
                        index_next = res_reg.idx;
                        start_next = res_reg.start;
                        end_next   = (res_reg.size == '0) ? res_reg.start
                                     : res_reg.start + res_reg.size - SIZE_W'(1);
                        bsize_next = res_reg.size;
                        frag_next  = (res_reg.cmd == CMD_ALLOC) ? res_reg.frag : '0;
                    end
                    else
                    begin
                        index_next = '0;
                        start_next = '0;
                        end_next   = '0;
                        bsize_next = '0;
                        frag_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(1);
            used_top_reg  <= SIZE_W'(OS_SIZE);
            launch_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_top_reg  <= used_top_next;
            launch_reg    <= launch_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        bsize_reg  <= bsize_next;
        frag_reg   <= frag_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.block_index = index_reg;
    assign rsp.start_addr  = start_reg;
    assign rsp.end_addr    = end_reg;
    assign rsp.block_size  = bsize_reg;
    assign rsp.frag        = frag_reg;

endmodule

`default_nettype wire

// ===== src/ffp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffp_cell #(
    parameter int CELL_IDX = 0,
    parameter int OS_SIZE  = 20
) (
    input  wire              clk,
    input  wire              rst_n,
    input  ffp_pkg::token_t  tok_in,
    output ffp_pkg::token_t  tok_out
);
    import ffp_pkg::*;

    localparam logic              IS_OS    = (CELL_IDX == 0);
    localparam logic [SIZE_W-1:0] RST_SIZE = IS_OS ? SIZE_W'(OS_SIZE) : '0;

    logic              valid_reg, valid_next;
    logic              busy_reg, busy_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] start_reg, start_next;
    token_t            tok_reg, tok_next;
    logic              claim_add, claim_alloc;

    always_comb
    begin
        claim_add   = tok_in.active && (tok_in.cmd == CMD_ADD) && !tok_in.found && !valid_reg;
        claim_alloc = tok_in.active && (tok_in.cmd == CMD_ALLOC) && !tok_in.found
                      && valid_reg && !busy_reg && (size_reg >= tok_in.req);

        valid_next = valid_reg;
        busy_next  = busy_reg;
        size_next  = size_reg;
        start_next = start_reg;
        tok_next   = tok_in;

        if (claim_add)
        begin
            // valid cells form a prefix, so the first empty cell is the next entry
            valid_next     = 1'b1;
            busy_next      = 1'b0;
            size_next      = tok_in.size;
            start_next     = tok_in.start;
            tok_next.found = 1'b1;
            tok_next.idx   = IDX_W'(CELL_IDX);
        end
        else if (claim_alloc)
        begin
            busy_next      = 1'b1;
            tok_next.found = 1'b1;
            tok_next.idx   = IDX_W'(CELL_IDX);
            tok_next.start = start_reg;
            tok_next.size  = size_reg;
            tok_next.frag  = size_reg - tok_in.req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= IS_OS;
            busy_reg  <= IS_OS;
            size_reg  <= RST_SIZE;
            start_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
            size_reg  <= size_next;
            start_reg <= start_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
